/* rtl/pfi_pkg.sv */
// pfi_pkg: shared constants, codes, types and helpers of the particle force integrator.
// No dependencies; used by every module in rtl/ except pfi_checker.
package pfi_pkg;

  // fixed point format
  localparam int FRAC_BITS  = 16;
  localparam int DAMP_FRAC  = 16;
  localparam logic [15:0] DAMP_RESET = 16'd328;
  localparam int WORD_W     = 32;
  // quotient width of the divider: quotients never exceed 2^FRAC_BITS
  localparam int QUO_W      = FRAC_BITS + 1;
  // dividend width: a 32-bit value shifted up by FRAC_BITS
  localparam int NUM_W      = WORD_W + FRAC_BITS;
  localparam int SQRT_STEPS = WORD_W;

  // request commands
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_FORCE = 3'd1;
  localparam logic [2:0] CMD_DAMP  = 3'd2;
  localparam logic [2:0] CMD_REPEL = 3'd3;
  localparam logic [2:0] CMD_INTEG = 3'd4;
  localparam logic [2:0] CMD_LOAD  = 3'd5;

  // datapath operations issued by the controller
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_CAPTURE  = 5'd1;
  localparam logic [4:0] OP_EXEC     = 5'd2;
  localparam logic [4:0] OP_DAMP_MUL = 5'd3;
  localparam logic [4:0] OP_DAMP_ADD = 5'd4;
  localparam logic [4:0] OP_VEL      = 5'd5;
  localparam logic [4:0] OP_POS      = 5'd6;
  localparam logic [4:0] OP_DIFF     = 5'd7;
  localparam logic [4:0] OP_SQ       = 5'd8;
  localparam logic [4:0] OP_SQRT_GO  = 5'd9;
  localparam logic [4:0] OP_CHK      = 5'd10;
  localparam logic [4:0] OP_PCT_LAT  = 5'd11;
  localparam logic [4:0] OP_DIV_UX   = 5'd12;
  localparam logic [4:0] OP_UX_LAT   = 5'd13;
  localparam logic [4:0] OP_DIV_UY   = 5'd14;
  localparam logic [4:0] OP_UY_LAT   = 5'd15;
  localparam logic [4:0] OP_M1       = 5'd16;
  localparam logic [4:0] OP_M2       = 5'd17;
  localparam logic [4:0] OP_FSAT     = 5'd18;
  localparam logic [4:0] OP_FADD     = 5'd19;
  localparam logic [4:0] OP_OUT      = 5'd20;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic skip;
    logic rad_pos;
  } dp_stat_t;

  // clamp a 34-bit signed sum to 32 bits
  function automatic sat_t sat34(input logic signed [33:0] v);
    sat_t r;
    if (v[33:31] != {3{v[33]}}) begin
      r.ovf = 1'b1;
      r.val = v[33] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // magnitude of a signed word, as unsigned
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

  function automatic logic signed [33:0] ext34(input logic [31:0] v);
    logic signed [33:0] r;
    r = {{2{v[31]}}, v};
    return r;
  endfunction

endpackage

/* rtl/pfi_sqrt.sv */
// pfi_sqrt: iterative integer square root, two radicand bits per cycle.
// Depends on pfi_pkg.
module pfi_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  localparam int CNT_W = $clog2(pfi_pkg::SQRT_STEPS);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      rad_r;
  logic [33:0]      rem_r;
  logic [31:0]      root_r;
  logic [35:0]      rem2;
  logic [35:0]      trial;
  logic             take;

  // one digit-by-digit step
  always_comb begin
    rem2  = {rem_r, rad_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    take  = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(pfi_pkg::SQRT_STEPS - 1)) busy_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      rem_r  <= take ? 34'(rem2 - trial) : rem2[33:0];
      root_r <= {root_r[30:0], take};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

/* rtl/pfi_div.sv */
// pfi_div: restoring divider, one quotient bit per cycle, quotient below 2^(FRAC_BITS+1).
// Depends on pfi_pkg.
module pfi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pfi_pkg::NUM_W-1:0]    num,
  input  logic [31:0]                  den,
  output logic                         busy,
  output logic [pfi_pkg::QUO_W-1:0]    quo
);

  localparam int QW    = pfi_pkg::QUO_W;
  localparam int NW    = pfi_pkg::NUM_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [QW-1:0]    lo_r;
  logic [QW-1:0]    quo_r;
  logic [32:0]      rem2;
  logic             take;

  always_comb begin
    rem2 = {rem_r, lo_r[QW-1]};
    take = (rem2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QW - 1)) busy_r <= 1'b0;
    end
  end

  // upper dividend bits are known to be below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num[NW-1:QW]};
      lo_r  <= num[QW-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? 32'(rem2 - {1'b0, den_r}) : rem2[31:0];
      lo_r  <= {lo_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], take};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* rtl/pfi_dp.sv */
// pfi_dp: particle state, arithmetic and result register; runs one operation per cycle.
// Depends on pfi_pkg, pfi_sqrt and pfi_div.
module pfi_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [4:0]              op,
  output pfi_pkg::dp_stat_t       stat,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata,
  input  logic [2:0]              in_command,
  input  logic signed [31:0]      in_arg_x,
  input  logic signed [31:0]      in_arg_y,
  input  logic signed [31:0]      in_reach_radius,
  input  logic signed [31:0]      in_strength_scale,
  input  logic signed [31:0]      in_load_vel_x,
  input  logic signed [31:0]      in_load_vel_y,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_vel_x,
  output logic signed [31:0]      out_vel_y,
  output logic                    out_saturated
);

  localparam int F  = pfi_pkg::FRAC_BITS;
  localparam int QW = pfi_pkg::QUO_W;
  localparam int NW = pfi_pkg::NUM_W;

  // captured request
  logic [2:0]         cmd_r;
  logic signed [31:0] ax_r, ay_r, rad_r, scl_r, lvx_r, lvy_r;
  // particle state
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, frc_x_r, frc_y_r;
  logic [15:0]        gain_r;
  logic               flag_r;
  // work registers
  logic [31:0]        dmx_r, dmy_r;
  logic signed [31:0] dx_r, dy_r;
  logic [63:0]        sqx_r, sqy_r;
  logic [QW-1:0]      pct_r, ux_r, uy_r, tx_r, ty_r;
  logic [32:0]        fmx_r, fmy_r;
  logic signed [31:0] ftx_r, fty_r;
  // result register
  logic signed [31:0] o_px_r, o_py_r, o_vx_r, o_vy_r;
  logic               o_sat_r;

  logic [31:0]        len;
  logic               sq_busy, dv_busy, dv_start;
  logic [NW-1:0]      dv_num;
  logic [31:0]        dv_den;
  logic [QW-1:0]      dv_quo;
  logic               rad_pos, skip;
  logic signed [63:0] psqx, psqy;
  logic [2*QW-1:0]    pm1x, pm1y;
  logic [QW+31:0]     pm2x, pm2y;
  logic [47:0]        pdx, pdy;
  pfi_pkg::sat_t      s_a, s_b, s_c, s_d;
  logic               neg_x, neg_y;

  // reach test on the measured distance
  assign rad_pos = !rad_r[31] && (rad_r != 32'sd0);
  assign skip    = (len == 32'd0) || (rad_pos && (len > rad_r));
  assign stat    = '{sqrt_busy: sq_busy, div_busy: dv_busy, skip: skip, rad_pos: rad_pos};

  // shared divider operand select
  always_comb begin
    dv_start = (op == pfi_pkg::OP_DIV_UX) || (op == pfi_pkg::OP_DIV_UY) ||
               ((op == pfi_pkg::OP_CHK) && !skip && rad_pos);
    if (op == pfi_pkg::OP_CHK) begin
      dv_num = {32'(rad_r - $signed(len)), {F{1'b0}}};
      dv_den = rad_r;
    end else if (op == pfi_pkg::OP_DIV_UX) begin
      dv_num = {pfi_pkg::mag32(dx_r), {F{1'b0}}};
      dv_den = len;
    end else begin
      dv_num = {pfi_pkg::mag32(dy_r), {F{1'b0}}};
      dv_den = len;
    end
  end

  pfi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == pfi_pkg::OP_SQRT_GO),
    .radicand (sqx_r + sqy_r),
    .busy     (sq_busy),
    .root     (len)
  );

  pfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .busy  (dv_busy),
    .quo   (dv_quo)
  );

  // products; each feeds a register
  always_comb begin
    psqx  = dx_r * dx_r;
    psqy  = dy_r * dy_r;
    pdx   = pfi_pkg::mag32(vel_x_r) * gain_r;
    pdy   = pfi_pkg::mag32(vel_y_r) * gain_r;
    pm1x  = ux_r * pct_r;
    pm1y  = uy_r * pct_r;
    pm2x  = tx_r * pfi_pkg::mag32(scl_r);
    pm2y  = ty_r * pfi_pkg::mag32(scl_r);
    neg_x = dx_r[31] ^ scl_r[31];
    neg_y = dy_r[31] ^ scl_r[31];
  end

  // saturating adders, shared by operation
  always_comb begin
    s_a = '0;
    s_b = '0;
    s_c = '0;
    s_d = '0;
    case (op)
      pfi_pkg::OP_EXEC: begin
        s_a = pfi_pkg::sat34(pfi_pkg::ext34(frc_x_r) + pfi_pkg::ext34(ax_r));
        s_b = pfi_pkg::sat34(pfi_pkg::ext34(frc_y_r) + pfi_pkg::ext34(ay_r));
      end
      pfi_pkg::OP_DAMP_ADD: begin
        s_a = pfi_pkg::sat34(vel_x_r[31] ? pfi_pkg::ext34(frc_x_r) + $signed({2'b00, dmx_r})
                                         : pfi_pkg::ext34(frc_x_r) - $signed({2'b00, dmx_r}));
        s_b = pfi_pkg::sat34(vel_y_r[31] ? pfi_pkg::ext34(frc_y_r) + $signed({2'b00, dmy_r})
                                         : pfi_pkg::ext34(frc_y_r) - $signed({2'b00, dmy_r}));
      end
      pfi_pkg::OP_VEL: begin
        s_a = pfi_pkg::sat34(pfi_pkg::ext34(vel_x_r) + pfi_pkg::ext34(frc_x_r));
        s_b = pfi_pkg::sat34(pfi_pkg::ext34(vel_y_r) + pfi_pkg::ext34(frc_y_r));
      end
      pfi_pkg::OP_POS: begin
        s_a = pfi_pkg::sat34(pfi_pkg::ext34(pos_x_r) + pfi_pkg::ext34(vel_x_r));
        s_b = pfi_pkg::sat34(pfi_pkg::ext34(pos_y_r) + pfi_pkg::ext34(vel_y_r));
      end
      pfi_pkg::OP_DIFF: begin
        s_a = pfi_pkg::sat34(pfi_pkg::ext34(pos_x_r) - pfi_pkg::ext34(ax_r));
        s_b = pfi_pkg::sat34(pfi_pkg::ext34(pos_y_r) - pfi_pkg::ext34(ay_r));
      end
      pfi_pkg::OP_FSAT: begin
        s_c = pfi_pkg::sat34(neg_x ? -$signed({1'b0, fmx_r}) : $signed({1'b0, fmx_r}));
        s_d = pfi_pkg::sat34(neg_y ? -$signed({1'b0, fmy_r}) : $signed({1'b0, fmy_r}));
      end
      pfi_pkg::OP_FADD: begin
        s_a = pfi_pkg::sat34(pfi_pkg::ext34(frc_x_r) + pfi_pkg::ext34(ftx_r));
        s_b = pfi_pkg::sat34(pfi_pkg::ext34(frc_y_r) + pfi_pkg::ext34(fty_r));
      end
      default: begin
      end
    endcase
  end

  // control-like state: damping register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= pfi_pkg::DAMP_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // particle state, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      frc_x_r <= '0;
      frc_y_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      case (op)
        pfi_pkg::OP_CAPTURE: flag_r <= 1'b0;
        pfi_pkg::OP_EXEC: begin
          case (cmd_r)
            pfi_pkg::CMD_CLEAR: begin
              frc_x_r <= '0;
              frc_y_r <= '0;
            end
            pfi_pkg::CMD_FORCE: begin
              frc_x_r <= s_a.val;
              frc_y_r <= s_b.val;
              flag_r  <= flag_r | s_a.ovf | s_b.ovf;
            end
            pfi_pkg::CMD_LOAD: begin
              pos_x_r <= ax_r;
              pos_y_r <= ay_r;
              vel_x_r <= lvx_r;
              vel_y_r <= lvy_r;
            end
            default: begin
            end
          endcase
        end
        pfi_pkg::OP_DAMP_ADD, pfi_pkg::OP_FADD: begin
          frc_x_r <= s_a.val;
          frc_y_r <= s_b.val;
          flag_r  <= flag_r | s_a.ovf | s_b.ovf;
        end
        pfi_pkg::OP_VEL: begin
          vel_x_r <= s_a.val;
          vel_y_r <= s_b.val;
          flag_r  <= flag_r | s_a.ovf | s_b.ovf;
        end
        pfi_pkg::OP_POS: begin
          pos_x_r <= s_a.val;
          pos_y_r <= s_b.val;
          flag_r  <= flag_r | s_a.ovf | s_b.ovf;
        end
        pfi_pkg::OP_DIFF: flag_r <= flag_r | s_a.ovf | s_b.ovf;
        pfi_pkg::OP_FSAT: flag_r <= flag_r | s_c.ovf | s_d.ovf;
        default: begin
        end
      endcase
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    case (op)
      pfi_pkg::OP_CAPTURE: begin
        cmd_r <= in_command;
        ax_r  <= in_arg_x;
        ay_r  <= in_arg_y;
        rad_r <= in_reach_radius;
        scl_r <= in_strength_scale;
        lvx_r <= in_load_vel_x;
        lvy_r <= in_load_vel_y;
      end
      pfi_pkg::OP_DAMP_MUL: begin
        dmx_r <= pdx[pfi_pkg::DAMP_FRAC +: 32];
        dmy_r <= pdy[pfi_pkg::DAMP_FRAC +: 32];
      end
      pfi_pkg::OP_DIFF: begin
        dx_r <= s_a.val;
        dy_r <= s_b.val;
      end
      pfi_pkg::OP_SQ: begin
        sqx_r <= psqx;
        sqy_r <= psqy;
      end
      pfi_pkg::OP_CHK: begin
        if (!rad_pos) pct_r <= {1'b1, {F{1'b0}}};
      end
      pfi_pkg::OP_PCT_LAT: pct_r <= dv_quo;
      pfi_pkg::OP_UX_LAT:  ux_r  <= dv_quo;
      pfi_pkg::OP_UY_LAT:  uy_r  <= dv_quo;
      pfi_pkg::OP_M1: begin
        tx_r <= pm1x[2*F:F];
        ty_r <= pm1y[2*F:F];
      end
      pfi_pkg::OP_M2: begin
        fmx_r <= pm2x[F+32:F];
        fmy_r <= pm2y[F+32:F];
      end
      pfi_pkg::OP_FSAT: begin
        ftx_r <= s_c.val;
        fty_r <= s_d.val;
      end
      pfi_pkg::OP_OUT: begin
        o_px_r  <= pos_x_r;
        o_py_r  <= pos_y_r;
        o_vx_r  <= vel_x_r;
        o_vy_r  <= vel_y_r;
        o_sat_r <= flag_r;
      end
      default: begin
      end
    endcase
  end

  assign out_pos_x     = o_px_r;
  assign out_pos_y     = o_py_r;
  assign out_vel_x     = o_vx_r;
  assign out_vel_y     = o_vy_r;
  assign out_saturated = o_sat_r;

endmodule

/* rtl/pfi_ctrl.sv */
// pfi_ctrl: sequencer that accepts a request, steps the datapath and hands off the result.
// Depends on pfi_pkg.
module pfi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_command,
  output logic              out_valid,
  input  logic              out_ready,
  input  pfi_pkg::dp_stat_t stat,
  output logic [4:0]        op
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_EXEC = 5'd1;
  localparam logic [4:0] S_DMUL = 5'd2;
  localparam logic [4:0] S_DADD = 5'd3;
  localparam logic [4:0] S_VEL  = 5'd4;
  localparam logic [4:0] S_POS  = 5'd5;
  localparam logic [4:0] S_DIFF = 5'd6;
  localparam logic [4:0] S_SQ   = 5'd7;
  localparam logic [4:0] S_SQS  = 5'd8;
  localparam logic [4:0] S_SQW  = 5'd9;
  localparam logic [4:0] S_CHK  = 5'd10;
  localparam logic [4:0] S_PCW  = 5'd11;
  localparam logic [4:0] S_UXS  = 5'd12;
  localparam logic [4:0] S_UXW  = 5'd13;
  localparam logic [4:0] S_UYS  = 5'd14;
  localparam logic [4:0] S_UYW  = 5'd15;
  localparam logic [4:0] S_M1   = 5'd16;
  localparam logic [4:0] S_M2   = 5'd17;
  localparam logic [4:0] S_FSAT = 5'd18;
  localparam logic [4:0] S_FADD = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       can_load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign can_load  = !ovalid_r || out_ready;

  // next state and datapath operation
  always_comb begin
    state_nxt  = state_r;
    op         = pfi_pkg::OP_NONE;
    ovalid_nxt = ovalid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = pfi_pkg::OP_CAPTURE;
          case (in_command)
            pfi_pkg::CMD_DAMP:  state_nxt = S_DMUL;
            pfi_pkg::CMD_REPEL: state_nxt = S_DIFF;
            pfi_pkg::CMD_INTEG: state_nxt = S_VEL;
            default:            state_nxt = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin op = pfi_pkg::OP_EXEC;     state_nxt = S_DONE; end
      S_DMUL: begin op = pfi_pkg::OP_DAMP_MUL; state_nxt = S_DADD; end
      S_DADD: begin op = pfi_pkg::OP_DAMP_ADD; state_nxt = S_DONE; end
      S_VEL:  begin op = pfi_pkg::OP_VEL;      state_nxt = S_POS;  end
      S_POS:  begin op = pfi_pkg::OP_POS;      state_nxt = S_DONE; end
      S_DIFF: begin op = pfi_pkg::OP_DIFF;     state_nxt = S_SQ;   end
      S_SQ:   begin op = pfi_pkg::OP_SQ;       state_nxt = S_SQS;  end
      S_SQS:  begin op = pfi_pkg::OP_SQRT_GO;  state_nxt = S_SQW;  end
      S_SQW: begin
        if (!stat.sqrt_busy) state_nxt = S_CHK;
      end
      // out of reach or zero distance ends the request here
      S_CHK: begin
        op = pfi_pkg::OP_CHK;
        if (stat.skip)         state_nxt = S_DONE;
        else if (stat.rad_pos) state_nxt = S_PCW;
        else                   state_nxt = S_UXS;
      end
      S_PCW: begin
        if (!stat.div_busy) begin
          op        = pfi_pkg::OP_PCT_LAT;
          state_nxt = S_UXS;
        end
      end
      S_UXS: begin op = pfi_pkg::OP_DIV_UX; state_nxt = S_UXW; end
      S_UXW: begin
        if (!stat.div_busy) begin
          op        = pfi_pkg::OP_UX_LAT;
          state_nxt = S_UYS;
        end
      end
      S_UYS: begin op = pfi_pkg::OP_DIV_UY; state_nxt = S_UYW; end
      S_UYW: begin
        if (!stat.div_busy) begin
          op        = pfi_pkg::OP_UY_LAT;
          state_nxt = S_M1;
        end
      end
      S_M1:   begin op = pfi_pkg::OP_M1;   state_nxt = S_M2;   end
      S_M2:   begin op = pfi_pkg::OP_M2;   state_nxt = S_FSAT; end
      S_FSAT: begin op = pfi_pkg::OP_FSAT; state_nxt = S_FADD; end
      S_FADD: begin op = pfi_pkg::OP_FADD; state_nxt = S_DONE; end
      // hand the state to the result register once it is free
      S_DONE: begin
        if (can_load) begin
          op         = pfi_pkg::OP_OUT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

/* rtl/particle_force_integrator.sv */
// particle_force_integrator: top level of the 2-D particle integrator.
// Depends on pfi_pkg, pfi_ctrl and pfi_dp.
//
// Usage:
// - Input channel in_valid/in_ready carries one request: a command plus its
//   Q16.16 arguments. Output channel out_valid/out_ready returns exactly one
//   result per request: position, velocity and a saturation flag.
// - cfg_we/cfg_wdata writes the damping gain (Q0.16); write it only while no
//   request is in flight.
// - One request at a time. Clear, add force, load and unused codes run the
//   execute operation; damping runs multiply then add, and integrate updates
//   velocity then position. Repulsion runs the square root (32 steps) and the
//   shared divider (17 steps per quotient): three divisions with a positive
//   radius, two with unlimited reach, none out of reach or at zero distance.
// - in_ready rises together with out_valid, so the next request may be taken
//   while the previous result still waits.
// - If the receiver stalls, a finished request holds in the sequencer until
//   the result register frees; the result stays stable while stalled.
// - Synchronous reset clears position, velocity, force and the channels, and
//   sets the damping gain to 328.
module particle_force_integrator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_arg_x,
  input  logic signed [31:0] in_arg_y,
  input  logic signed [31:0] in_reach_radius,
  input  logic signed [31:0] in_strength_scale,
  input  logic signed [31:0] in_load_vel_x,
  input  logic signed [31:0] in_load_vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  pfi_pkg::dp_stat_t stat;
  logic [4:0]        op;

  pfi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .op         (op)
  );

  pfi_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_arg_x          (in_arg_x),
    .in_arg_y          (in_arg_y),
    .in_reach_radius   (in_reach_radius),
    .in_strength_scale (in_strength_scale),
    .in_load_vel_x     (in_load_vel_x),
    .in_load_vel_y     (in_load_vel_y),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_vel_x         (out_vel_x),
    .out_vel_y         (out_vel_y),
    .out_saturated     (out_saturated)
  );

endmodule

/* rtl/pfi_checker.sv */
// pfi_checker: port-level assertions for particle_force_integrator, bound to the top.
// Depends only on the top level's ports.
module pfi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_vel_y,
  input logic               out_saturated
);

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_vel_y)
      && $stable(out_saturated))
    else $error("stalled result changed");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind particle_force_integrator pfi_checker u_pfi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x     (out_pos_x),
  .out_vel_y     (out_vel_y),
  .out_saturated (out_saturated)
);

/* tb/sv/particle_force_integrator_chk.sv */
// particle_force_integrator_chk: watches the request, result and gain-write ports,
// predicts each result from its own copy of the particle state and compares.
// Depends on pfi_pkg for the command codes and fixed-point constants.
module particle_force_integrator_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_arg_x,
  input  logic signed [31:0] in_arg_y,
  input  logic signed [31:0] in_reach_radius,
  input  logic signed [31:0] in_strength_scale,
  input  logic signed [31:0] in_load_vel_x,
  input  logic signed [31:0] in_load_vel_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_vel_x,
  input  logic signed [31:0] out_vel_y,
  input  logic               out_saturated,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               sat;
  } particle_state_t;

  // model copy of the particle
  longint px, py, vx, vy, fx, fy;
  logic [15:0] gain;
  particle_state_t state_q[$];

  function automatic longint clamp32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // product shifted right, truncated toward zero
  function automatic longint scale_down(input longint a, input longint b, input int sh);
    longint unsigned p;
    p = (abs64(a) * abs64(b)) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned root64(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // radial push away from (cx, cy)
  task automatic repulse(input longint cx, input longint cy, input longint rad,
                         input longint scl, inout bit f);
    longint dx, dy, ux, uy, tx, ty;
    longint unsigned len, pct;
    dx = clamp32(px - cx, f);
    dy = clamp32(py - cy, f);
    len = root64(longint'(dx * dx) + longint'(dy * dy));
    if (rad > 0 && len > longint'(rad)) return;
    if (len == 0) return;
    if (rad > 0) pct = ((longint'(rad) - len) << pfi_pkg::FRAC_BITS) / longint'(rad);
    else pct = 64'd1 << pfi_pkg::FRAC_BITS;
    ux = longint'((abs64(dx) << pfi_pkg::FRAC_BITS) / len);
    if (dx < 0) ux = -ux;
    uy = longint'((abs64(dy) << pfi_pkg::FRAC_BITS) / len);
    if (dy < 0) uy = -uy;
    tx = clamp32(scale_down(scale_down(ux, longint'(pct), pfi_pkg::FRAC_BITS), scl,
                            pfi_pkg::FRAC_BITS), f);
    ty = clamp32(scale_down(scale_down(uy, longint'(pct), pfi_pkg::FRAC_BITS), scl,
                            pfi_pkg::FRAC_BITS), f);
    fx = clamp32(fx + tx, f);
    fy = clamp32(fy + ty, f);
  endtask

  task automatic apply_request(output particle_state_t r);
    bit f;
    f = 1'b0;
    case (in_command)
      pfi_pkg::CMD_CLEAR: begin
        fx = 0;
        fy = 0;
      end
      pfi_pkg::CMD_FORCE: begin
        fx = clamp32(fx + longint'(in_arg_x), f);
        fy = clamp32(fy + longint'(in_arg_y), f);
      end
      pfi_pkg::CMD_DAMP: begin
        fx = clamp32(fx - scale_down(vx, longint'(gain), pfi_pkg::DAMP_FRAC), f);
        fy = clamp32(fy - scale_down(vy, longint'(gain), pfi_pkg::DAMP_FRAC), f);
      end
      pfi_pkg::CMD_REPEL: begin
        repulse(longint'(in_arg_x), longint'(in_arg_y), longint'(in_reach_radius),
                longint'(in_strength_scale), f);
      end
      pfi_pkg::CMD_INTEG: begin
        vx = clamp32(vx + fx, f);
        vy = clamp32(vy + fy, f);
        px = clamp32(px + vx, f);
        py = clamp32(py + vy, f);
      end
      pfi_pkg::CMD_LOAD: begin
        px = longint'(in_arg_x);
        py = longint'(in_arg_y);
        vx = longint'(in_load_vel_x);
        vy = longint'(in_load_vel_y);
      end
      default: ;
    endcase
    r.pos_x = px[31:0];
    r.pos_y = py[31:0];
    r.vel_x = vx[31:0];
    r.vel_y = vy[31:0];
    r.sat = f;
  endtask

  function automatic int cmp_field(input string name, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    particle_state_t e;
    int bad;
    if (!rst_n) begin
      px = 0; py = 0; vx = 0; vy = 0; fx = 0; fy = 0;
      gain = pfi_pkg::DAMP_RESET;
      state_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (state_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          fail_count++;
        end else begin
          e = state_q.pop_front();
          bad = cmp_field("pos_x", e.pos_x, out_pos_x)
              + cmp_field("pos_y", e.pos_y, out_pos_y)
              + cmp_field("vel_x", e.vel_x, out_vel_x)
              + cmp_field("vel_y", e.vel_y, out_vel_y)
              + cmp_field("saturated", {31'd0, e.sat}, {31'd0, out_saturated});
          if (bad != 0) fail_count++;
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        apply_request(e);
        state_q.push_back(e);
      end
      if (cfg_we) gain = cfg_wdata;
    end
    pending = state_q.size();
  end

endmodule

/* tb/sv/particle_force_integrator_tb.sv */
// particle_force_integrator_tb: drives requests and gain writes into the particle
// integrator under random idling and gives the verdict.
// Depends on pfi_pkg, particle_force_integrator and particle_force_integrator_chk.
module particle_force_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = pfi_pkg::CMD_CLEAR;
  logic signed [31:0] in_arg_x = '0, in_arg_y = '0, in_reach_radius = '0;
  logic signed [31:0] in_strength_scale = '0, in_load_vel_x = '0, in_load_vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int fail_count, pending, checked;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_go = 1'b0;
  int requests = 0;
  int quiet = 0;
  logic signed [31:0] anchor_x = '0, anchor_y = '0;

  particle_force_integrator u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_arg_x, .in_arg_y,
    .in_reach_radius, .in_strength_scale, .in_load_vel_x, .in_load_vel_y,
    .out_valid, .out_ready, .out_pos_x, .out_pos_y, .out_vel_x, .out_vel_y,
    .out_saturated, .cfg_we, .cfg_wdata
  );

  particle_force_integrator_chk u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_arg_x, .in_arg_y,
    .in_reach_radius, .in_strength_scale, .in_load_vel_x, .in_load_vel_y,
    .out_valid, .out_ready, .out_pos_x, .out_pos_y, .out_vel_x, .out_vel_y,
    .out_saturated, .cfg_we, .cfg_wdata, .fail_count, .pending, .checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        hold = LONG_HOLD;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", pending);
      $display("particle_force_integrator_tb NOT OK");
      $finish;
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [31:0] ax, input logic [31:0] ay,
                      input logic [31:0] rad, input logic [31:0] scl,
                      input logic [31:0] lvx, input logic [31:0] lvy);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_arg_x <= ax;
    in_arg_y <= ay;
    in_reach_radius <= rad;
    in_strength_scale <= scl;
    in_load_vel_x <= lvx;
    in_load_vel_y <= lvy;
    do @(posedge clk); while (!in_ready);
    requests++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_gain(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly small magnitudes, sometimes full range or an extreme
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3, 4: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(32'h0fff_ffff)) - 32'sh0800_0000;
    endcase
  endfunction

  // offset of a repulsion center from the anchor, mostly within reach
  function automatic logic [31:0] near(input logic [31:0] base);
    return base + ($signed($urandom_range(32'h0007_ffff)) - 32'sh0004_0000);
  endfunction

  task automatic rand_request();
    logic [31:0] r;
    case ($urandom_range(19))
      0: send(pfi_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
      1, 2: send(pfi_pkg::CMD_FORCE, pick_word(), pick_word(), $urandom, $urandom,
                 $urandom, $urandom);
      3, 4: send(pfi_pkg::CMD_DAMP, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
      5, 6, 7, 8, 9: begin
        case ($urandom_range(3))
          0: r = $urandom;
          1: r = -$signed($urandom_range(32'h0010_0000));
          default: r = $urandom_range(32'h0010_0000, 1);
        endcase
        if ($urandom_range(7) == 0)
          send(pfi_pkg::CMD_REPEL, pick_word(), pick_word(), r, pick_word(), $urandom,
               $urandom);
        else
          send(pfi_pkg::CMD_REPEL, near(anchor_x), near(anchor_y), r,
               $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000, $urandom, $urandom);
      end
      10, 11, 12, 13: send(pfi_pkg::CMD_INTEG, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
      14, 15, 16: begin
        anchor_x = pick_word();
        anchor_y = pick_word();
        send(pfi_pkg::CMD_LOAD, anchor_x, anchor_y, $urandom, $urandom, pick_word(),
             pick_word());
      end
      17: send(pfi_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
      default: send(3'd6 + 3'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
    endcase
  endtask

  task automatic directed();
    send(pfi_pkg::CMD_FORCE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0);
    send(pfi_pkg::CMD_FORCE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0);
    send(pfi_pkg::CMD_INTEG, 0, 0, 0, 0, 0, 0);
    send(pfi_pkg::CMD_INTEG, 0, 0, 0, 0, 0, 0);
    send(pfi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send(pfi_pkg::CMD_LOAD, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff,
         32'h8000_0000);
    send(pfi_pkg::CMD_DAMP, 0, 0, 0, 0, 0, 0);
    send(pfi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    // far corners: difference saturates
    send(pfi_pkg::CMD_REPEL, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 0);
    send(pfi_pkg::CMD_LOAD, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0);
    // zero distance leaves the force alone
    send(pfi_pkg::CMD_REPEL, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000,
         0, 0);
    // out of reach, then inside, then unlimited with zero and negative radius
    send(pfi_pkg::CMD_REPEL, 32'h0009_0000, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000,
         0, 0);
    send(pfi_pkg::CMD_REPEL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000,
         0, 0);
    send(pfi_pkg::CMD_REPEL, 32'h0002_0000, 32'h0003_0000, 0, 32'h8000_0000, 0, 0);
    send(pfi_pkg::CMD_REPEL, 32'h0000_0000, 32'h0002_0000, 32'hffff_0000, 32'h7fff_ffff,
         0, 0);
    send(pfi_pkg::CMD_REPEL, 32'h0001_0001, 32'h0002_0000, 32'h0000_0001, 32'h0001_0000,
         0, 0);
    send(pfi_pkg::CMD_INTEG, 0, 0, 0, 0, 0, 0);
    send(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
         32'hffff_ffff);
    send(3'd7, 0, 0, 0, 0, 0, 0);
    send(pfi_pkg::CMD_LOAD, 0, 0, 0, 0, 32'h0000_8000, 32'hffff_8000);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles lightly, receiver heavily; reset gain
    send_idle = 17;
    recv_idle = 65;
    directed();
    hold_go = 1'b1;
    repeat (12) rand_request();
    hold_go = 1'b0;
    repeat (300) rand_request();
    drain();
    repeat (300) rand_request();
    write_gain(16'hffff);
    repeat (100) rand_request();

    // phase 2: roles swapped
    send_idle = 65;
    recv_idle = 17;
    write_gain(16'h0000);
    repeat (600) rand_request();

    // phase 3: no idling
    send_idle = 0;
    recv_idle = 0;
    write_gain(16'($urandom));
    repeat (300) rand_request();
    write_gain(16'h8000);
    repeat (300) rand_request();

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d requests over all commands, %0d results checked,", requests,
             checked);
    $display("three idling phases and damping gains from zero to full scale");
    if (fail_count == 0 && pending == 0) begin
      $display("particle_force_integrator_tb OK");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending);
      $display("particle_force_integrator_tb NOT OK");
    end
    $finish;
  end

endmodule
